// ===== design/ssm_pkg.sv =====
`timescale 1ns / 1ps

package ssm_pkg;

    // Default series length and fixed field widths
    localparam int MAX_DAYS_DEF = 256;
    localparam int PRICE_W      = 32;
    localparam int SPAN_W       = 9;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_DONE = 3'b100
    } ssm_state_t;

    // Shift command broadcast to every cell of the chain
    typedef struct packed {
        logic push;   // take the entry from the cell above (toward the top)
        logic pop;    // take the entry from the cell below (toward the bottom)
    } ssm_shift_t;

endpackage

// ===== design/ssm_in_if.sv =====
`timescale 1ns / 1ps

interface ssm_in_if import ssm_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [PRICE_W-1:0]  price;
    logic                       last;

    modport source (output valid, output price, output last, input ready);
    modport sink   (input valid, input price, input last, output ready);
endinterface

// ===== design/ssm_out_if.sv =====
`timescale 1ns / 1ps

interface ssm_out_if import ssm_pkg::*;;
    logic               valid;
    logic               ready;
    logic [SPAN_W-1:0]  span;
    logic               overflow;

    modport source (output valid, output span, output overflow, input ready);
    modport sink   (input valid, input span, input overflow, output ready);
endinterface

// ===== design/ssm_cell.sv =====
`timescale 1ns / 1ps

module ssm_cell import ssm_pkg::*;
#(
    parameter int DAY_W = 8
)
(
    input  logic                       clk,
    input  ssm_shift_t                 shift,
    input  logic signed [PRICE_W-1:0]  up_price,
    input  logic        [DAY_W-1:0]    up_day,
    input  logic signed [PRICE_W-1:0]  dn_price,
    input  logic        [DAY_W-1:0]    dn_day,
    output logic signed [PRICE_W-1:0]  price,
    output logic        [DAY_W-1:0]    day
);

    logic signed [PRICE_W-1:0] price_reg, price_next;
    logic        [DAY_W-1:0]   day_reg, day_next;

    // Push moves entries down the chain, pop moves them up
    always_comb
    begin
        price_next = price_reg;
        day_next   = day_reg;
        if (shift.push)
        begin
            price_next = up_price;
            day_next   = up_day;
        end
        else if (shift.pop)
        begin
            price_next = dn_price;
            day_next   = dn_day;
        end
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        day_reg   <= day_next;
    end

    assign price = price_reg;
    assign day   = day_reg;

endmodule

// ===== design/stock_span_monotonic_stack_core.sv =====
`timescale 1ns / 1ps

// Channel   Dir   Beat payload          Handshake
// item      in    price[31:0], last     valid/ready
// result    out   span[8:0], overflow   valid/ready
//
// An item is accepted in IDLE, then POP retires the entries it pops and DONE
// pushes it; the single comparator at the top cell of the chain retires one
// pop per cycle. Each entry is popped at most once; an overflowed item is not pushed.
// rst_n clears the sequencer, the stack depth and the day counter; the cells
// hold payload only. The result register stays full while result is stalled;
// the next item is already accepted and waits in the DONE state for it.

module stock_span_monotonic_stack_core import ssm_pkg::*;
#(
    parameter int MAX_DAYS = MAX_DAYS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    ssm_in_if.sink       item,
    ssm_out_if.source    result
);

    localparam int DAY_W = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;
    localparam int CNT_W = $clog2(MAX_DAYS + 1);
    localparam int SW    = (CNT_W > SPAN_W) ? CNT_W : SPAN_W;

    ssm_state_t                 state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           day_idx_reg, day_idx_next;
    logic signed [PRICE_W-1:0]  price_reg, price_next;
    logic                       last_reg, last_next;
    logic                       out_valid_reg, out_valid_next;
    logic [SPAN_W-1:0]          span_reg, span_next;
    logic                       ovf_reg, ovf_next;

    ssm_shift_t                 shift;
    logic signed [PRICE_W-1:0]  cell_price [MAX_DAYS];
    logic        [DAY_W-1:0]    cell_day   [MAX_DAYS];
    logic signed [PRICE_W-1:0]  dn_price   [MAX_DAYS];
    logic        [DAY_W-1:0]    dn_day     [MAX_DAYS];

    logic                       ovf;
    logic                       top_le;
    logic                       out_free;
    logic [SW-1:0]              span_wide;

    // Chain of cells, cell 0 is the top of stack
    genvar gi;
    generate
        for (gi = 0; gi < MAX_DAYS; gi++)
        begin : g_cell
            if (gi == MAX_DAYS - 1)
            begin : g_bot
                assign dn_price[gi] = cell_price[gi];
                assign dn_day[gi]   = cell_day[gi];
            end
            else
            begin : g_mid
                assign dn_price[gi] = cell_price[gi+1];
                assign dn_day[gi]   = cell_day[gi+1];
            end

            if (gi == 0)
            begin : g_top
                ssm_cell #(.DAY_W(DAY_W)) u_cell (
                    .clk      (clk),
                    .shift    (shift),
                    .up_price (price_reg),
                    .up_day   (day_idx_reg[DAY_W-1:0]),
                    .dn_price (dn_price[gi]),
                    .dn_day   (dn_day[gi]),
                    .price    (cell_price[gi]),
                    .day      (cell_day[gi])
                );
            end
            else
            begin : g_rest
                ssm_cell #(.DAY_W(DAY_W)) u_cell (
                    .clk      (clk),
                    .shift    (shift),
                    .up_price (cell_price[gi-1]),
                    .up_day   (cell_day[gi-1]),
                    .dn_price (dn_price[gi]),
                    .dn_day   (dn_day[gi]),
                    .price    (cell_price[gi]),
                    .day      (cell_day[gi])
                );
            end
        end
    endgenerate

    // Top-of-stack compare and span
    assign ovf      = (day_idx_reg == CNT_W'(MAX_DAYS));
    assign top_le   = (count_reg != '0) && (cell_price[0] <= price_reg);
    assign out_free = !out_valid_reg || result.ready;
    assign span_wide = (count_reg == '0) ? (SW'(day_idx_reg) + SW'(1))
                                         : (SW'(day_idx_reg) - SW'(cell_day[0]));

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        day_idx_next   = day_idx_reg;
        price_next     = price_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        span_next      = span_reg;
        ovf_next       = ovf_reg;
        shift          = '0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    price_next = item.price;
                    last_next  = item.last;
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (!ovf && top_le)
                begin
                    shift.pop  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (ovf)
                    begin
                        span_next = '0;
                        ovf_next  = 1'b1;
                    end
                    else
                    begin
                        span_next    = span_wide[SPAN_W-1:0];
                        ovf_next     = 1'b0;
                        shift.push   = 1'b1;
                        count_next   = count_reg + CNT_W'(1);
                        day_idx_next = day_idx_reg + CNT_W'(1);
                    end
                    // End of series clears the stack
                    if (last_reg)
                    begin
                        count_next   = '0;
                        day_idx_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            day_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            day_idx_reg   <= day_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        last_reg  <= last_next;
        span_reg  <= span_next;
        ovf_reg   <= ovf_next;
    end

    assign item.ready      = (state_reg == S_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.span     = span_reg;
    assign result.overflow = ovf_reg;

endmodule
